### src/svm_pkg.sv
// svm_pkg: shared types and constants of the six-voice sample mixer
// no dependencies; used by svm_mix_dp, six_voice_sample_mixer_core and the testbench
package svm_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_CMD    = 2'd1,
		OP_VOLUME = 2'd2,
		OP_LOAD   = 2'd3
	} op_t;

	typedef struct packed {
		logic clear;
		logic smp_valid;
		logic halve;
	} mix_ctl_t;

	localparam int          NUM_LEN_REGS   = 6;
	localparam int          LEN_W          = 14;
	localparam int          CFG_IDX_W      = 3;
	localparam int          MASK_W         = 6;
	localparam logic [13:0] LEN_RESET      = 14'd8192;
	localparam logic [11:0] GAIN_RESET     = 12'd2048;
	localparam logic [8:0]  SMP_CENTER     = 9'd128;
	localparam int          GAIN_SHIFT     = 12;
	localparam int          DAC_MAX        = 255;
	localparam logic [8:0]  TRIGGER_PERIOD = 9'd500;
	localparam logic [7:0]  CMD_ONESHOT    = 8'h70;
	localparam logic [7:0]  CMD_VOICE1     = 8'h31;

endpackage

### src/svm_mix_dp.sv
// svm_mix_dp: shared gain multiplier, mix accumulator and dac scaling
// depends on svm_pkg (mix_ctl_t, constants)
module svm_mix_dp #(
	parameter int NUM_VOICES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  svm_pkg::mix_ctl_t ctl,
	input  logic [7:0]        smp,
	input  logic [11:0]       gain,
	output logic              busy,
	output logic [9:0]        dac
);
	import svm_pkg::*;

	localparam int ACC_W = 9 + $clog2(NUM_VOICES);

	logic signed [8:0]       diff;
	logic signed [12:0]      gain_x;
	logic signed [21:0]      mul_full;
	logic signed [20:0]      prod_s2;
	logic                    valid_s2;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] half;
	logic signed [ACC_W:0]   sum;
	logic [7:0]              mix8;

	assign diff     = $signed({1'b0, smp} - SMP_CENTER);
	assign gain_x   = $signed({1'b0, gain});
	assign mul_full = diff * gain_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_full[20:0];
	end

	// term is the product shifted right by the gain shift, floor rounding
	assign term = {{(ACC_W-8){prod_s2[19]}}, prod_s2[GAIN_SHIFT+7:GAIN_SHIFT]};

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + term;
		end
	end

	assign half = ctl.halve ? (acc_q >>> 1) : acc_q;
	assign sum  = $signed({half[ACC_W-1], half}) + $signed((ACC_W+1)'(SMP_CENTER));

	always_comb begin
		if (sum < 0) begin
			mix8 = '0;
		end else if (sum > $signed((ACC_W+1)'(DAC_MAX))) begin
			mix8 = 8'(DAC_MAX);
		end else begin
			mix8 = sum[7:0];
		end
	end

	assign dac  = {mix8, 2'b00};
	assign busy = valid_s2;

endmodule

### src/six_voice_sample_mixer_core.sv
// six_voice_sample_mixer_core: top level, voice sequencer, sample memory, registers
// depends on svm_pkg and svm_mix_dp
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_ready   | operation command_byte volume_level load_*
//  out      | out_valid / out_ready | dac_valid dac_value adc_trigger active_mask
//           |                       | one_shot_on
//  cfg      | cfg_wen               | cfg_idx cfg_data
//
// a tick beat visits one voice per cycle through the single sample memory read port and
// shared multiplier, then drains the read, multiply and accumulate registers before its
// result is loaded into the output register; the next beat is taken in the cycle after
// that load. other beats go straight to the done state and load their result from there.
// in_ready is low from acceptance until the result is loaded into the output register;
// a stalled output holds the block in its last state.
// reset resets voices, lengths, gain, mode and trigger count; sample memory has no reset.
module six_voice_sample_mixer_core #(
	parameter int NUM_VOICES     = 6,
	parameter int MAX_SAMPLE_LEN = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [7:0]                     command_byte,
	input  logic [11:0]                    volume_level,
	input  logic [2:0]                     load_voice,
	input  logic [12:0]                    load_address,
	input  logic [7:0]                     load_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           dac_valid,
	output logic [9:0]                     dac_value,
	output logic                           adc_trigger,
	output logic [svm_pkg::MASK_W-1:0]     active_mask,
	output logic                           one_shot_on,
	input  logic                           cfg_wen,
	input  logic [svm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [svm_pkg::LEN_W-1:0]      cfg_data
);
	import svm_pkg::*;

	localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int PW    = $clog2(MAX_SAMPLE_LEN);
	localparam int LW    = $clog2(MAX_SAMPLE_LEN + 1);
	localparam int EW    = (LW > LEN_W) ? LW : LEN_W;
	localparam int DEPTH = NUM_VOICES * MAX_SAMPLE_LEN;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q [NUM_VOICES];
	logic [PW-1:0]     pos_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] on_q;
	logic              oneshot_q;
	logic [11:0]       gain_q;
	logic [8:0]        trig_cnt_q;
	logic [VW-1:0]     vc_q;
	logic              tick_q;
	logic              seen_q;
	logic              multi_q;

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rdata_s1;
	logic              valid_s1;

	logic              accept;
	op_t               op;
	logic [7:0]        cmd_k;
	logic              cmd_voice_ok;
	logic              load_ok;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic              rd_en;
	logic [EW-1:0]     eff_len;
	logic [EW-1:0]     len_ext;
	logic [EW-1:0]     pos_nxt;
	logic              wrap;
	logic              out_load;
	logic              trig_hit;

	mix_ctl_t          ctl;
	logic              dp_busy;
	logic [9:0]        dp_dac;

	logic              out_valid_q;
	logic              dac_valid_q;
	logic [9:0]        dac_value_q;
	logic              adc_trigger_q;
	logic [MASK_W-1:0] active_mask_q;
	logic              one_shot_q;
	logic [MASK_W-1:0] mask_now;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign op       = op_t'(operation);

	assign cmd_k        = command_byte - CMD_VOICE1;
	assign cmd_voice_ok = (command_byte >= CMD_VOICE1) && (32'(cmd_k) < NUM_VOICES)
		&& (32'(cmd_k) < NUM_LEN_REGS);
	assign load_ok      = (32'(load_voice) < NUM_VOICES) && (32'(load_address) < MAX_SAMPLE_LEN);
	assign mem_we       = accept && (op == OP_LOAD) && load_ok;
	assign wr_addr      = AW'(load_voice) * AW'(MAX_SAMPLE_LEN) + AW'(load_address);

	// effective length: zero plays as one, saturate at memory size
	assign len_ext = EW'(len_q[vc_q]);
	always_comb begin
		if (len_ext == '0) begin
			eff_len = EW'(1);
		end else if (len_ext > EW'(MAX_SAMPLE_LEN)) begin
			eff_len = EW'(MAX_SAMPLE_LEN);
		end else begin
			eff_len = len_ext;
		end
	end

	assign pos_nxt = EW'(pos_q[vc_q]) + EW'(1);
	assign wrap    = (pos_nxt >= eff_len);
	assign rd_en   = (state_q == ST_RUN) && on_q[vc_q];
	assign rd_addr = AW'(vc_q) * AW'(MAX_SAMPLE_LEN) + AW'(pos_q[vc_q]);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= load_byte;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	assign ctl.clear     = accept && (op == OP_TICK);
	assign ctl.smp_valid = valid_s1;
	assign ctl.halve     = multi_q;

	svm_mix_dp #(
		.NUM_VOICES(NUM_VOICES)
	) u_mix_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.smp    (rdata_s1),
		.gain   (gain_q),
		.busy   (dp_busy),
		.dac    (dp_dac)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign trig_hit = (trig_cnt_q == TRIGGER_PERIOD - 9'd1);

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < NUM_VOICES; i++) begin
				len_q[i] <= LEN_RESET;
				pos_q[i] <= '0;
			end
			on_q       <= '0;
			oneshot_q  <= 1'b0;
			gain_q     <= GAIN_RESET;
			trig_cnt_q <= '0;
			vc_q       <= '0;
			tick_q     <= 1'b0;
			seen_q     <= 1'b0;
			multi_q    <= 1'b0;
		end else begin
			if (cfg_wen && (32'(cfg_idx) < NUM_VOICES) && (32'(cfg_idx) < NUM_LEN_REGS)) begin
				len_q[cfg_idx[VW-1:0]] <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_q <= (op == OP_TICK);
						case (op)
							OP_TICK: begin
								vc_q    <= '0;
								seen_q  <= 1'b0;
								multi_q <= 1'b0;
								state_q <= ST_RUN;
							end
							OP_CMD: begin
								if (command_byte == CMD_ONESHOT) begin
									oneshot_q <= !oneshot_q;
								end else if (cmd_voice_ok) begin
									on_q[cmd_k[VW-1:0]] <= !on_q[cmd_k[VW-1:0]];
									if (!on_q[cmd_k[VW-1:0]]) begin
										pos_q[cmd_k[VW-1:0]] <= '0;
									end
								end
								state_q <= ST_DONE;
							end
							OP_VOLUME: begin
								gain_q  <= volume_level;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (on_q[vc_q]) begin
						seen_q <= 1'b1;
						if (seen_q) begin
							multi_q <= 1'b1;
						end
						if (wrap) begin
							pos_q[vc_q] <= '0;
							if (oneshot_q) begin
								on_q[vc_q] <= 1'b0;
							end
						end else begin
							pos_q[vc_q] <= pos_nxt[PW-1:0];
						end
					end
					if (vc_q == VW'(NUM_VOICES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						vc_q <= vc_q + VW'(1);
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !dp_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						if (tick_q) begin
							trig_cnt_q <= trig_hit ? '0 : trig_cnt_q + 9'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mask_now = '0;
		for (int i = 0; i < NUM_VOICES && i < MASK_W; i++) begin
			mask_now[i] = on_q[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dac_valid_q   <= tick_q;
			dac_value_q   <= tick_q ? dp_dac : '0;
			adc_trigger_q <= tick_q && trig_hit;
			active_mask_q <= mask_now;
			one_shot_q    <= oneshot_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign dac_valid   = dac_valid_q;
	assign dac_value   = dac_value_q;
	assign adc_trigger = adc_trigger_q;
	assign active_mask = active_mask_q;
	assign one_shot_on = one_shot_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block ready right after accepting a beat");

	a_trig_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dac_valid |-> !adc_trigger && (dac_value == '0))
		else $error("non-tick result carries dac data");

	a_mac_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_busy || valid_s1) |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("sample pipeline active outside a tick");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		trig_cnt_q < TRIGGER_PERIOD)
		else $error("trigger counter out of range");

endmodule

### sim/testbench.sv
// testbench for six_voice_sample_mixer_core: directed beats, then phases of random beats
// under new voice lengths, each result checked against a fixed expected value or an in-bench mixer predictor
// depends on svm_pkg and six_voice_sample_mixer_core
module testbench;
	import svm_pkg::*;

	localparam int VOICES     = 6;
	localparam int SAMPLE_LEN = 8192;
	localparam int LIMIT      = 600000;
	localparam int NUM_ITEMS  = 400;

	typedef struct packed {
		op_t         op;
		logic [7:0]  cmd;
		logic [11:0] vol;
		logic [2:0]  lv;
		logic [12:0] la;
		logic [7:0]  lb;
	} mix_item_t;

	typedef struct packed {
		logic       dac_valid;
		logic [9:0] dac_value;
		logic       adc_trigger;
		logic [5:0] active_mask;
		logic       one_shot_on;
	} mix_result_t;

	typedef struct packed {
		mix_item_t   it;
		logic        typed;
		mix_result_t res;
	} vector_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [1:0]        operation    = OP_TICK;
	logic [7:0]        command_byte = '0;
	logic [11:0]       volume_level = '0;
	logic [2:0]        load_voice   = '0;
	logic [12:0]       load_address = '0;
	logic [7:0]        load_byte    = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic              dac_valid;
	logic [9:0]        dac_value;
	logic              adc_trigger;
	logic [MASK_W-1:0] active_mask;
	logic              one_shot_on;
	logic              cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [LEN_W-1:0]  cfg_data     = '0;

	// predictor state
	bit [7:0]  voice_mem [VOICES][SAMPLE_LEN];
	bit        mem_written [VOICES][SAMPLE_LEN];
	bit [12:0] pos_q [VOICES];
	bit [13:0] len_q [VOICES];
	bit [5:0]  on_q;
	bit        oneshot_q;
	bit [11:0] gain_q;
	int        trig_cnt;

	mix_result_t pending_results [$];
	mix_result_t want;
	int errors;
	int items_sent;
	int burst_left;
	int rx_cycle;

	six_voice_sample_mixer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.command_byte (command_byte),
		.volume_level (volume_level),
		.load_voice   (load_voice),
		.load_address (load_address),
		.load_byte    (load_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dac_valid    (dac_valid),
		.dac_value    (dac_value),
		.adc_trigger  (adc_trigger),
		.active_mask  (active_mask),
		.one_shot_on  (one_shot_on),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic mix_result_t mix_and_advance(mix_item_t it);
		mix_result_t r;
		int acc;
		int term;
		int n_on;
		int eff;
		int k;
		r = '0;
		case (it.op)
			OP_TICK: begin
				acc = 0;
				n_on = 0;
				for (k = 0; k < VOICES; k++) begin
					if (on_q[k]) begin
						term = (int'(voice_mem[k][pos_q[k]]) - int'(SMP_CENTER)) * int'(gain_q);
						acc = acc + (term >>> GAIN_SHIFT);
						eff = (len_q[k] == 0) ? 1 :
							(int'(len_q[k]) > SAMPLE_LEN ? SAMPLE_LEN : int'(len_q[k]));
						if (int'(pos_q[k]) + 1 >= eff) begin
							pos_q[k] = '0;
							if (oneshot_q)
								on_q[k] = 1'b0;
						end else begin
							pos_q[k] = pos_q[k] + 13'd1;
						end
						n_on++;
					end
				end
				if (n_on > 1)
					acc = acc >>> 1;
				acc = acc + int'(SMP_CENTER);
				if (acc > DAC_MAX)
					acc = DAC_MAX;
				if (acc < 0)
					acc = 0;
				r.dac_valid = 1'b1;
				r.dac_value = {acc[7:0], 2'b00};
				trig_cnt++;
				if (trig_cnt >= int'(TRIGGER_PERIOD)) begin
					trig_cnt = 0;
					r.adc_trigger = 1'b1;
				end
			end
			OP_CMD: begin
				if (it.cmd == CMD_ONESHOT) begin
					oneshot_q = ~oneshot_q;
				end else if (it.cmd >= CMD_VOICE1 &&
						int'(it.cmd) - int'(CMD_VOICE1) < VOICES) begin
					k = int'(it.cmd) - int'(CMD_VOICE1);
					on_q[k] = ~on_q[k];
					if (on_q[k])
						pos_q[k] = '0;
				end
			end
			OP_VOLUME: begin
				gain_q = it.vol;
			end
			default: begin
				if (it.lv < VOICES) begin
					voice_mem[it.lv][it.la] = it.lb;
					mem_written[it.lv][it.la] = 1'b1;
				end
			end
		endcase
		r.active_mask = on_q;
		r.one_shot_on = oneshot_q;
		return r;
	endfunction

	function automatic vector_t row(op_t op, logic [7:0] cmd, logic [11:0] vol,
			logic [2:0] lv, logic [12:0] la, logic [7:0] lb, bit typed, logic dv,
			logic [9:0] dac, logic trig, logic [5:0] mask, logic os);
		vector_t v;
		v.it.op = op;
		v.it.cmd = cmd;
		v.it.vol = vol;
		v.it.lv = lv;
		v.it.la = la;
		v.it.lb = lb;
		v.typed = typed;
		v.res.dac_valid = dv;
		v.res.dac_value = dac;
		v.res.adc_trigger = trig;
		v.res.active_mask = mask;
		v.res.one_shot_on = os;
		return v;
	endfunction

	function automatic mix_item_t random_beat();
		mix_item_t it;
		int pick;
		it.cmd = 8'($urandom);
		it.vol = 12'($urandom);
		it.lv = 3'($urandom);
		it.la = 13'($urandom);
		it.lb = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			it.op = OP_TICK;
		end else if (pick < 76) begin
			it.op = OP_CMD;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				it.cmd = CMD_VOICE1 + 8'($urandom_range(0, VOICES - 1));
			else if (pick < 85)
				it.cmd = CMD_ONESHOT;
		end else if (pick < 83) begin
			it.op = OP_VOLUME;
			pick = $urandom_range(0, 99);
			if (pick < 15)
				it.vol = '0;
			else if (pick < 30)
				it.vol = '1;
		end else begin
			it.op = OP_LOAD;
			if ($urandom_range(0, 19) == 0)
				it.lv = 3'($urandom_range(VOICES, 7));
			else
				it.lv = 3'($urandom_range(0, VOICES - 1));
			if ($urandom_range(0, 3) != 0)
				it.la = 13'($urandom_range(0, 31));
		end
		return it;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len(int mode);
		case (mode)
			0: return LEN_W'($urandom_range(1, 12));
			1: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return LEN_W'(1);
					2: return LEN_RESET;
					default: return '1;
				endcase
			end
			2: return LEN_W'($urandom_range(0, 16383));
			default: return LEN_W'($urandom_range(0, 4));
		endcase
	endfunction

	task automatic send_item(input mix_item_t it, input bit typed, input mix_result_t typed_res);
		int idle;
		mix_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle = $urandom_range(0, 12);
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		operation    <= it.op;
		command_byte <= it.cmd;
		volume_level <= it.vol;
		load_voice   <= it.lv;
		load_address <= it.la;
		load_byte    <= it.lb;
		do
			@(posedge clk);
		while (!in_ready);
		r = mix_and_advance(it);
		pending_results.push_back(typed ? typed_res : r);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// caller lowers cfg_wen after the last write
	task automatic write_reg(input int idx, input logic [LEN_W-1:0] val);
		cfg_wen  <= 1'b1;
		cfg_idx  <= idx[CFG_IDX_W-1:0];
		cfg_data <= val;
		@(posedge clk);
		if (idx < VOICES)
			len_q[idx] = val;
	endtask

	task automatic compare_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with none pending, dac_value %0d", $time, dac_value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("dac_valid", int'(want.dac_valid), int'(dac_valid));
				compare_field("dac_value", int'(want.dac_value), int'(dac_value));
				compare_field("adc_trigger", int'(want.adc_trigger), int'(adc_trigger));
				compare_field("active_mask", int'(want.active_mask), int'(active_mask));
				compare_field("one_shot_on", int'(want.one_shot_on), int'(one_shot_on));
			end
		end
		rx_cycle++;
		case ((rx_cycle >> 7) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= (rx_cycle % 5) != 0;
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (rx_cycle % 11) < 3;
		endcase
	end

	initial begin
		vector_t directed_beats [25];
		mix_item_t it;
		mix_item_t fill;
		int p;
		int n;
		int k;
		int count;
		for (k = 0; k < VOICES; k++)
			len_q[k] = LEN_RESET;
		gain_q = GAIN_RESET;

		directed_beats[0]  = row(OP_TICK,   8'h00, 0,    0, 0,    0,   1, 1, 512,  0, 6'h00, 0);
		directed_beats[1]  = row(OP_CMD,    8'h78, 0,    0, 0,    0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[2]  = row(OP_CMD,    8'h30, 0,    0, 0,    0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[3]  = row(OP_CMD,    8'h37, 0,    0, 0,    0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[4]  = row(OP_CMD,    CMD_ONESHOT, 0, 0, 0,  0,   1, 0, 0,    0, 6'h00, 1);
		directed_beats[5]  = row(OP_CMD,    CMD_ONESHOT, 0, 0, 0,  0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[6]  = row(OP_LOAD,   8'h00, 0,    6, 0,    255, 1, 0, 0,    0, 6'h00, 0);
		directed_beats[7]  = row(OP_LOAD,   8'h00, 0,    7, 8191, 0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[8]  = row(OP_LOAD,   8'h00, 0,    0, 0,    255, 1, 0, 0,    0, 6'h00, 0);
		directed_beats[9]  = row(OP_LOAD,   8'h00, 0,    1, 0,    255, 1, 0, 0,    0, 6'h00, 0);
		directed_beats[10] = row(OP_LOAD,   8'h00, 0,    5, 0,    255, 1, 0, 0,    0, 6'h00, 0);
		directed_beats[11] = row(OP_LOAD,   8'h00, 0,    5, 8191, 0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[12] = row(OP_VOLUME, 8'h00, 4095, 0, 0,    0,   1, 0, 0,    0, 6'h00, 0);
		directed_beats[13] = row(OP_CMD,    8'h31, 0,    0, 0,    0,   1, 0, 0,    0, 6'h01, 0);
		directed_beats[14] = row(OP_CMD,    8'h32, 0,    0, 0,    0,   1, 0, 0,    0, 6'h03, 0);
		directed_beats[15] = row(OP_CMD,    8'h36, 0,    0, 0,    0,   1, 0, 0,    0, 6'h23, 0);
		// three loud voices clamp high
		directed_beats[16] = row(OP_TICK,   8'h00, 0,    0, 0,    0,   1, 1, 1020, 0, 6'h23, 0);
		directed_beats[17] = row(OP_LOAD,   8'h00, 0,    0, 1,    0,   0, 0, 0,    0, 0,     0);
		directed_beats[18] = row(OP_LOAD,   8'h00, 0,    1, 1,    0,   0, 0, 0,    0, 0,     0);
		directed_beats[19] = row(OP_LOAD,   8'h00, 0,    5, 1,    0,   0, 0, 0,    0, 0,     0);
		// three quiet voices clamp low
		directed_beats[20] = row(OP_TICK,   8'h00, 0,    0, 0,    0,   1, 1, 0,    0, 6'h23, 0);
		directed_beats[21] = row(OP_VOLUME, 8'h00, 0,    0, 0,    0,   0, 0, 0,    0, 0,     0);
		directed_beats[22] = row(OP_CMD,    8'h31, 0,    0, 0,    0,   1, 0, 0,    0, 6'h22, 0);
		directed_beats[23] = row(OP_CMD,    8'h32, 0,    0, 0,    0,   1, 0, 0,    0, 6'h20, 0);
		directed_beats[24] = row(OP_CMD,    8'h36, 0,    0, 0,    0,   1, 0, 0,    0, 6'h00, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < 25; n++)
			send_item(directed_beats[n].it, directed_beats[n].typed, directed_beats[n].res);

		p = 0;
		while (items_sent < NUM_ITEMS) begin
			drain();
			for (k = 0; k < VOICES; k++)
				write_reg(k, pick_len(p % 4));
			write_reg($urandom_range(NUM_LEN_REGS, 7), LEN_W'($urandom));
			cfg_wen <= 1'b0;
			count = $urandom_range(40, 90);
			if (count > NUM_ITEMS - items_sent)
				count = NUM_ITEMS - items_sent;
			for (n = 0; n < count; n++) begin
				it = random_beat();
				// fill every not yet written sample that this tick is about to read
				if (it.op == OP_TICK) begin
					for (k = 0; k < VOICES; k++) begin
						if (on_q[k] && !mem_written[k][pos_q[k]]) begin
							fill = random_beat();
							fill.op = OP_LOAD;
							fill.lv = 3'(k);
							fill.la = pos_q[k];
							send_item(fill, 1'b0, '0);
						end
					end
				end
				send_item(it, 1'b0, '0);
			end
			p++;
		end

		drain();
		repeat (2 * (VOICES + 4)) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
